[sv/arqrx_pkg.sv]
// Shared types and constants for the ARQ window receiver.
`default_nettype none

package arqrx_pkg;

  localparam int FRAME_SEQ_W = 16;
  localparam int ACK_W       = 17;
  localparam int LIMIT_W     = 16;
  localparam int BASE_W      = 17;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  // Receiver modes
  localparam logic MODE_GBN = 1'b0;
  localparam logic MODE_SR  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE        = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 16'd10;

  typedef struct packed {
    logic                   frame_present;
    logic                   is_data;
    logic [FRAME_SEQ_W-1:0] frame_seq;
  } item_t;

  typedef struct packed {
    logic signed [ACK_W-1:0] ack_seq;
    logic                    accepted;
    logic                    finished;
  } result_t;

  typedef struct packed {
    logic                mode;
    logic [LIMIT_W-1:0]  frame_limit;
  } cfg_t;

endpackage

`default_nettype wire

[sv/arq_window_receiver.sv]
// Top level of the ARQ window receiver: ports, config registers, input and output stages.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: frame_present, frame_seq; tuser: is_data
//  out_    | out | out_tvalid/out_tready| tdata: ack_seq, accepted; tlast: finished
//  cfg_    | in  | cfg_we               | cfg_addr selects mode or frame_limit
//
// One word is taken every cycle unless a stalled output fills the input register; a
// result is offered once its word has passed through the input register and the
// combinational step has written the output register.
// The step is one pass through the sequence compare and the window bitmap AND.
// Reset is synchronous on rst_n low: all receiver state clears, mode returns to
// go-back-N and the frame limit to ten. A stalled output holds its word and the
// input register, and in_tready drops only while both are full.
// Words that produce no acknowledgement (after finishing) are dropped silently.
`default_nettype none

module arq_window_receiver #(
  parameter int WINDOW   = 4,
  parameter int SEQ_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [arqrx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [arqrx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input words
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [arqrx_pkg::IN_DATA_W-1:0]     in_tdata,  // [0] frame_present, [16:1] frame_seq
  input  wire logic                                in_tuser,  // [0] is_data
  // result words
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [arqrx_pkg::OUT_DATA_W-1:0]         out_tdata, // [16:0] ack_seq, [17] accepted
  output logic                                     out_tlast  // finished
);

  arqrx_pkg::cfg_t    cfg_r;
  logic               in_valid_r;
  arqrx_pkg::item_t   in_item_r;
  logic               out_valid_r;
  arqrx_pkg::result_t out_res_r;

  logic               advance;
  logic               fire;
  logic               res_valid;
  arqrx_pkg::result_t res;
  arqrx_pkg::item_t   in_item;

  // Hold the output word until taken; the step moves only when there is room.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign in_item.frame_present = in_tdata[0];
  assign in_item.frame_seq     = in_tdata[16:1];
  assign in_item.is_data       = in_tuser;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= arqrx_pkg::MODE_GBN;
      cfg_r.frame_limit <= arqrx_pkg::FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        arqrx_pkg::CFG_MODE:        cfg_r.mode        <= cfg_wdata[0];
        arqrx_pkg::CFG_FRAME_LIMIT: cfg_r.frame_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
  end

  arqrx_core #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register; drop words that yield no acknowledgement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.accepted, out_res_r.ack_seq};
  assign out_tlast  = out_res_r.finished;

  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result word changed");

  a_in_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the output had room");

  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(fire))
    else $error("result word raised without a step");

endmodule

`default_nettype wire

[sv/arqrx_core.sv]
// Receiver state and combinational step logic for the ARQ window receiver.
`default_nettype none

module arqrx_core #(
  parameter int WINDOW   = 4,
  parameter int SEQ_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire arqrx_pkg::item_t item,
  input  wire arqrx_pkg::cfg_t  cfg,
  output logic                  res_valid,
  output arqrx_pkg::result_t    res
);

  localparam int SEQ_W = (SEQ_BITS < arqrx_pkg::FRAME_SEQ_W) ? SEQ_BITS
                                                             : arqrx_pkg::FRAME_SEQ_W;
  localparam int OFF_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW    = arqrx_pkg::FRAME_SEQ_W;
  localparam int BW    = arqrx_pkg::BASE_W;

  logic [SEQ_W-1:0]  expected_r, expected_nxt;
  logic [BW-1:0]     base_r, base_nxt;
  logic [WINDOW-1:0] map_r, map_nxt;
  logic [FW-1:0]     last_acc_r, last_acc_nxt;
  logic              done_r, done_nxt;

  logic [SEQ_W-1:0]  seq_w;
  logic [FW-1:0]     seq16;
  logic [BW-1:0]     seq17;
  logic [BW-1:0]     off17;
  logic [OFF_W-1:0]  off_idx;
  logic              in_win;
  logic [BW-1:0]     cnt_now;
  logic [BW-1:0]     cnt_after;
  logic [BW-1:0]     limit17;
  logic [WINDOW-1:0] map_set;
  logic              acc;
  logic signed [arqrx_pkg::ACK_W-1:0] ack;

  always_comb begin
    seq_w   = SEQ_W'(item.frame_seq);
    seq16   = FW'(seq_w);
    seq17   = {1'b0, seq16};
    off17   = seq17 - base_r;
    off_idx = off17[OFF_W-1:0];
    in_win  = (seq17 >= base_r) && (off17 < BW'(WINDOW));
    limit17 = {1'b0, cfg.frame_limit};
    cnt_now = (cfg.mode == arqrx_pkg::MODE_SR) ? base_r : BW'(expected_r);

    expected_nxt = expected_r;
    base_nxt     = base_r;
    map_nxt      = map_r;
    last_acc_nxt = last_acc_r;
    done_nxt     = done_r;
    acc          = 1'b0;
    ack          = '0;
    map_set      = map_r;
    res_valid    = 1'b0;
    cnt_after    = cnt_now;

    if (fire && !done_r) begin
      if (cnt_now >= limit17) begin
        // limit already reached: finish silently
        done_nxt = 1'b1;
      end else begin
        res_valid = 1'b1;
        if (cfg.mode == arqrx_pkg::MODE_GBN) begin
          if (item.frame_present && item.is_data && (seq_w == expected_r)) begin
            expected_nxt = expected_r + 1'b1;
            acc          = 1'b1;
            // ack the new count less one, so a wrap to zero acks -1
            ack          = $signed({1'b0, FW'(expected_nxt)} - 1'b1);
          end else if (item.frame_present && (seq_w < expected_r)) begin
            ack = $signed(seq17 - 1'b1);
          end else begin
            ack = $signed({1'b0, FW'(expected_r)} - 1'b1);
          end
          cnt_after = BW'(expected_nxt);
        end else begin
          if (item.frame_present && item.is_data && in_win && !map_r[off_idx]) begin
            map_set[off_idx] = 1'b1;
            last_acc_nxt     = seq16;
            acc              = 1'b1;
            ack              = $signed(seq17);
          end else if (item.frame_present && (seq17 <= base_r)) begin
            ack = $signed(seq17);
          end else begin
            ack = $signed({1'b0, last_acc_r});
          end
          // advance a whole window once every slot is filled
          if (&map_set) begin
            base_nxt = base_r + BW'(WINDOW);
            map_nxt  = '0;
          end else begin
            map_nxt  = map_set;
          end
          cnt_after = base_nxt;
        end
        done_nxt = (cnt_after >= limit17);
      end
    end

    res.ack_seq  = ack;
    res.accepted = acc;
    res.finished = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      base_r     <= '0;
      map_r      <= '0;
      last_acc_r <= '0;
      done_r     <= 1'b0;
    end else begin
      expected_r <= expected_nxt;
      base_r     <= base_nxt;
      map_r      <= map_nxt;
      last_acc_r <= last_acc_nxt;
      done_r     <= done_nxt;
    end
  end

  a_done_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r && $stable(expected_r) && $stable(base_r) && $stable(last_acc_r))
    else $error("receiver state moved after finishing");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (fire && !done_r))
    else $error("result produced without a live word");

  a_map_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(&map_r))
    else $error("bitmap held full instead of advancing the window");

  a_base_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r != $past(base_r)) |-> (map_r == '0))
    else $error("window advanced without clearing the bitmap");

endmodule

`default_nettype wire
